// ----- hdl/lsr_pkg.sv -----
// Package for the LIFO stack with reverse: request, status and FSM state codes.
// No dependencies.

package lsr_pkg;

  typedef enum logic [2:0] {
    REQ_PUSH     = 3'd0,
    REQ_POP      = 3'd1,
    REQ_PEEK_TOP = 3'd2,
    REQ_PEEK_SEC = 3'd3,
    REQ_REVERSE  = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_REV_RD,
    S_REV_WLO,
    S_REV_WHI
  } state_t;

  localparam int REQ_BITS  = 3;
  localparam int WORD_BITS = 32;
  localparam int FILL_BITS = 6;

endpackage

// ----- hdl/lsr_if.sv -----
// Valid/ready channel interfaces for the LIFO stack: request and result.
// Depends on lsr_pkg.

interface lsr_in_if;
  import lsr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [REQ_BITS-1:0]  req_type;
  logic [WORD_BITS-1:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface lsr_out_if;
  import lsr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] read_value;
  logic [1:0]           status;
  logic [FILL_BITS-1:0] fill_count;
  logic                 is_empty;

  modport source (output valid, output read_value, output status, output fill_count,
                  output is_empty, input ready);
  modport sink   (input valid, input read_value, input status, input fill_count,
                  input is_empty, output ready);
endinterface

// ----- hdl/lsr_ram.sv -----
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.

module lsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- hdl/lifo_stack_with_reverse.sv -----
// LIFO stack with in-place reverse: control FSM around one stack RAM.
// Depends on lsr_pkg, lsr_if (lsr_in_if, lsr_out_if) and lsr_ram.
//
//   channel  | dir | contents
//   in_ch    | in  | req_type, push_value
//   out_ch   | out | read_value, status, fill_count, is_empty
//
// Push, refused requests and unknown codes load the result straight from S_IDLE.
// Pop and peeks go through S_READ (registered RAM read). Reverse of n >= 2 entries:
// one swap per S_REV_RD, S_REV_WLO, S_REV_WHI pass, through the single RAM write port.
// Reset is synchronous; the RAM is not cleared, only the count, state and result valid.
// A request is taken only when idle and the result register is free or being read.

module lifo_stack_with_reverse
  import lsr_pkg::*;
#(
  parameter int DEPTH     = 32,
  parameter int ITEM_BITS = 32
) (
  input logic clk,
  input logic rst_n,
  lsr_in_if.sink    in_ch,
  lsr_out_if.source out_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [AW-1:0]        lo_r, lo_nxt, hi_r, hi_nxt;
  logic [ITEM_BITS-1:0] save_r, save_nxt;

  logic                 out_valid_r;
  logic [WORD_BITS-1:0] out_read_r;
  logic [1:0]           out_status_r;
  logic [FILL_BITS-1:0] out_fill_r;
  logic                 out_empty_r;

  logic                 accept;
  logic                 full, has1, has2, rev_more;
  logic [CW-1:0]        cnt_m1, cnt_m2;
  logic [AW:0]          lo_p2;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [ITEM_BITS-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;

  logic                 res_load;
  logic [WORD_BITS-1:0] res_read;
  status_t              res_status;

  logic [ITEM_BITS+WORD_BITS-1:0] push_ext, rd_ext;
  logic [CW+FILL_BITS-1:0]        fill_ext;

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  assign full     = (count_r == CW'(DEPTH));
  assign has1     = (count_r != '0);
  assign has2     = (count_r >= CW'(2));
  assign cnt_m1   = count_r - CW'(1);
  assign cnt_m2   = count_r - CW'(2);
  assign lo_p2    = {1'b0, lo_r} + (AW + 1)'(2);
  assign rev_more = lo_p2 < {1'b0, hi_r};

  assign push_ext = {{ITEM_BITS{1'b0}}, in_ch.push_value};
  assign rd_ext   = {{WORD_BITS{1'b0}}, ram_rdata_a};
  assign fill_ext = {{FILL_BITS{1'b0}}, count_nxt};

  lsr_ram #(
    .WIDTH (ITEM_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  // next state and stack pointers
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    save_nxt  = save_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.req_type)
            REQ_PUSH: begin
              if (!full) count_nxt = count_r + CW'(1);
            end
            REQ_POP: begin
              if (has1) begin
                count_nxt = cnt_m1;
                state_nxt = S_READ;
              end
            end
            REQ_PEEK_TOP: begin
              if (has1) state_nxt = S_READ;
            end
            REQ_PEEK_SEC: begin
              if (has2) state_nxt = S_READ;
            end
            REQ_REVERSE: begin
              if (has2) begin
                lo_nxt    = '0;
                hi_nxt    = cnt_m1[AW-1:0];
                state_nxt = S_REV_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ:    state_nxt = S_IDLE;
      S_REV_RD:  state_nxt = S_REV_WLO;
      S_REV_WLO: begin
        save_nxt  = ram_rdata_a;
        state_nxt = S_REV_WHI;
      end
      S_REV_WHI: begin
        lo_nxt    = lo_r + AW'(1);
        hi_nxt    = hi_r - AW'(1);
        state_nxt = rev_more ? S_REV_RD : S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // RAM control and result generation
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = count_r[AW-1:0];
    ram_wdata   = push_ext[ITEM_BITS-1:0];
    ram_raddr_a = cnt_m1[AW-1:0];
    ram_raddr_b = hi_r;
    res_load    = 1'b0;
    res_read    = '0;
    res_status  = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_ch.req_type == REQ_PEEK_SEC) ram_raddr_a = cnt_m2[AW-1:0];
        if (accept) begin
          case (in_ch.req_type)
            REQ_PUSH: begin
              res_load = 1'b1;
              if (full) res_status = ST_OVER;
              else ram_we = 1'b1;
            end
            REQ_POP, REQ_PEEK_TOP: begin
              if (!has1) begin
                res_load   = 1'b1;
                res_status = ST_UNDER;
              end
            end
            REQ_PEEK_SEC: begin
              if (!has2) begin
                res_load   = 1'b1;
                res_status = ST_UNDER;
              end
            end
            REQ_REVERSE: res_load = !has2;
            default:     res_load = 1'b1;
          endcase
        end
      end
      S_READ: begin
        res_load = 1'b1;
        res_read = rd_ext[WORD_BITS-1:0];
      end
      S_REV_RD: begin
        ram_raddr_a = lo_r;
        ram_raddr_b = hi_r;
      end
      S_REV_WLO: begin
        ram_we    = 1'b1;
        ram_waddr = lo_r;
        ram_wdata = ram_rdata_b;
      end
      S_REV_WHI: begin
        ram_we    = 1'b1;
        ram_waddr = hi_r;
        ram_wdata = save_r;
        res_load  = !rev_more;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (res_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    save_r <= save_nxt;
    if (res_load) begin
      out_read_r   <= res_read;
      out_status_r <= res_status;
      out_fill_r   <= fill_ext[FILL_BITS-1:0];
      out_empty_r  <= (count_nxt == '0);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_read_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.fill_count = out_fill_r;
  assign out_ch.is_empty   = out_empty_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above DEPTH");

  a_no_result_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid_r || out_ch.ready))
    else $error("result overwrites an untaken transaction");

  a_over_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && res_status == ST_OVER) |-> full)
    else $error("overflow flagged while not full");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.req_type == REQ_POP && has1) |=> count_r == $past(cnt_m1))
    else $error("pop did not decrement the count");

endmodule

// ----- tb/tb_lifo_stack_with_reverse.sv -----
`timescale 1ns / 100ps
// Testbench for lifo_stack_with_reverse: directed and random stack requests,
// each result checked against a local stack predictor. Depends on lsr_pkg and lsr_if.

module tb_lifo_stack_with_reverse;
  import lsr_pkg::*;

  localparam int STACK_DEPTH = 32;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES = 64;
  localparam logic [REQ_BITS-1:0] REQ_UNK_FIRST = 3'd5;
  localparam logic [REQ_BITS-1:0] REQ_UNK_LAST = 3'd7;
  localparam int BIAS_MIX = 0;
  localparam int BIAS_FILL = 1;
  localparam int BIAS_DRAIN = 2;

  typedef struct packed {
    logic [WORD_BITS-1:0] read_value;
    status_t              status;
    logic [FILL_BITS-1:0] fill_count;
    logic                 is_empty;
  } stack_result_t;

  logic clk = 1'b0;
  logic rst_n;

  lsr_in_if  in_ch ();
  lsr_out_if out_ch ();

  lifo_stack_with_reverse #(
    .DEPTH    (STACK_DEPTH),
    .ITEM_BITS(WORD_BITS)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #4 clk = ~clk;

  logic [WORD_BITS-1:0] stack_mem [STACK_DEPTH];
  int                   stack_fill;
  stack_result_t        pending_results[$];
  int                   err_count;
  int                   tx_idle_pct;
  int                   rx_idle_pct;
  int                   quiet_cycles;

  function automatic stack_result_t predict_request(logic [REQ_BITS-1:0] code,
                                                    logic [WORD_BITS-1:0] value);
    stack_result_t res;
    logic [WORD_BITS-1:0] tmp;
    int lo;
    int hi;
    res.read_value = '0;
    res.status = ST_OK;
    case (code)
      REQ_PUSH: begin
        if (stack_fill >= STACK_DEPTH) begin
          res.status = ST_OVER;
        end else begin
          stack_mem[stack_fill] = value;
          stack_fill++;
        end
      end
      REQ_POP: begin
        if (stack_fill == 0) begin
          res.status = ST_UNDER;
        end else begin
          stack_fill--;
          res.read_value = stack_mem[stack_fill];
        end
      end
      REQ_PEEK_TOP: begin
        if (stack_fill == 0) res.status = ST_UNDER;
        else res.read_value = stack_mem[stack_fill-1];
      end
      REQ_PEEK_SEC: begin
        if (stack_fill < 2) res.status = ST_UNDER;
        else res.read_value = stack_mem[stack_fill-2];
      end
      REQ_REVERSE: begin
        lo = 0;
        hi = stack_fill - 1;
        while (lo < hi) begin
          tmp = stack_mem[lo];
          stack_mem[lo] = stack_mem[hi];
          stack_mem[hi] = tmp;
          lo++;
          hi--;
        end
      end
      default: ;
    endcase
    res.fill_count = stack_fill[FILL_BITS-1:0];
    res.is_empty = (stack_fill == 0);
    return res;
  endfunction

  // Sender: valid stays high between back-to-back transactions.
  task automatic send_req(input logic [REQ_BITS-1:0] code, input logic [WORD_BITS-1:0] value);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= code;
    in_ch.push_value <= value;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_request(code, value));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  function automatic logic [WORD_BITS-1:0] pick_value();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    stack_result_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: read_value %h", out_ch.read_value);
        err_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_ch.read_value !== exp_res.read_value) begin
          $error("read_value: expected %h, got %h", exp_res.read_value, out_ch.read_value);
          err_count++;
        end
        if (out_ch.status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_ch.status);
          err_count++;
        end
        if (out_ch.fill_count !== exp_res.fill_count) begin
          $error("fill_count: expected %0d, got %0d", exp_res.fill_count, out_ch.fill_count);
          err_count++;
        end
        if (out_ch.is_empty !== exp_res.is_empty) begin
          $error("is_empty: expected %0d, got %0d", exp_res.is_empty, out_ch.is_empty);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_empty_requests();
    send_req(REQ_POP, '1);
    send_req(REQ_PEEK_TOP, '0);
    send_req(REQ_PEEK_SEC, '0);
    send_req(REQ_REVERSE, '0);
    for (int c = int'(REQ_UNK_FIRST); c <= int'(REQ_UNK_LAST); c++)
      send_req(c[REQ_BITS-1:0], $urandom);
  endtask

  task automatic test_small_stack();
    send_req(REQ_PUSH, '0);
    send_req(REQ_PEEK_SEC, '0);
    send_req(REQ_REVERSE, '0);
    send_req(REQ_PEEK_TOP, '0);
    send_req(REQ_PUSH, '1);
    send_req(REQ_PEEK_TOP, '0);
    send_req(REQ_PEEK_SEC, '0);
    send_req(REQ_PUSH, 32'h5a5a_a5a5);
    send_req(REQ_REVERSE, '0);
    send_req(REQ_UNK_LAST, '0);
    send_req(REQ_PEEK_TOP, '0);
    send_req(REQ_POP, '0);
    send_req(REQ_POP, '0);
    send_req(REQ_POP, '0);
    send_req(REQ_POP, '0);
  endtask

  // Fill to capacity, try overflow, reverse a full stack, empty it, then pop once more.
  task automatic test_full_stack();
    while (stack_fill < STACK_DEPTH) send_req(REQ_PUSH, pick_value());
    send_req(REQ_PUSH, '1);
    send_req(REQ_PUSH, $urandom);
    send_req(REQ_PEEK_TOP, '0);
    send_req(REQ_PEEK_SEC, '0);
    send_req(REQ_REVERSE, '0);
    send_req(REQ_PEEK_TOP, '0);
    send_req(REQ_PEEK_SEC, '0);
    while (stack_fill > 0) send_req(REQ_POP, '0);
    send_req(REQ_POP, '0);
  endtask

  task automatic test_random(input int n_items);
    int bias;
    int seg_left;
    int push_w;
    int pop_w;
    int pick;
    logic [REQ_BITS-1:0] code;
    seg_left = 0;
    bias = BIAS_MIX;
    for (int i = 0; i < n_items; i++) begin
      if (seg_left == 0) begin
        bias = $urandom_range(BIAS_DRAIN);
        seg_left = $urandom_range(48, 16);
      end
      seg_left--;
      push_w = (bias == BIAS_FILL) ? 65 : (bias == BIAS_DRAIN) ? 10 : 30;
      pop_w  = (bias == BIAS_FILL) ? 8 : (bias == BIAS_DRAIN) ? 55 : 25;
      pick = $urandom_range(99);
      if (pick < push_w) begin
        code = REQ_PUSH;
      end else if (pick < push_w + pop_w) begin
        code = REQ_POP;
      end else begin
        pick = $urandom_range(99);
        if (pick < 35) code = REQ_PEEK_TOP;
        else if (pick < 70) code = REQ_PEEK_SEC;
        else if (pick < 90) code = REQ_REVERSE;
        else code = REQ_BITS'($urandom_range(REQ_UNK_LAST, REQ_UNK_FIRST));
      end
      send_req(code, pick_value());
      if (i == n_items / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_PUSH;
    in_ch.push_value = '0;
    out_ch.ready = 1'b0;
    err_count = 0;
    quiet_cycles = 0;
    stack_fill = 0;
    tx_idle_pct = 38;
    rx_idle_pct = 68;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_requests();
    test_small_stack();
    test_full_stack();
    test_random(560);

    tx_idle_pct = 68;
    rx_idle_pct = 38;
    test_random(560);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_full_stack();
    test_random(560);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
